// ----- hdl/greenhouse_relay_controller_defines.svh -----
// ----------------------------------------------------------------------------
// Greenhouse relay controller assertion macros
// Shared property wrappers for the checker of the relay controller.
// ----------------------------------------------------------------------------
`ifndef GREENHOUSE_RELAY_CONTROLLER_DEFINES_SVH
`define GREENHOUSE_RELAY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while rstn is low.
`define GRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("grc checker: same-cycle property violated");

// Next-cycle implication, disabled while rstn is low.
`define GRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("grc checker: next-cycle property violated");

`endif

// ----- hdl/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// Greenhouse relay controller package
// Widths, register indexes, status codes and reset values.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int TIME_W      = 32;
    localparam int TEMP_W      = 11;
    localparam int LEVEL_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Minimum spacing between accepted reads, in milliseconds.
    localparam logic [TIME_W-1:0] POLL_GAP_MS = 32'd1000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMP_HIGH_LIMIT = 3'd0,
        REG_TEMP_LOW_LIMIT  = 3'd1,
        REG_HUMIDITY_LIMIT  = 3'd2,
        REG_SOIL_DRY_LIMIT  = 3'd3,
        REG_LIGHT_LIMIT     = 3'd4,
        REG_PUMP_WORK_MS    = 3'd5,
        REG_PUMP_PAUSE_MS   = 3'd6,
        REG_FAN_MAX_MS      = 3'd7
    } cfg_index_t;

    // Poll outcome codes.
    typedef enum logic [STATUS_W-1:0] {
        POLL_EARLY     = 2'd0,
        POLL_FAULT     = 2'd1,
        POLL_REGULATED = 2'd2
    } poll_status_t;

    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RESET = 11'sd300;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RESET  = 11'sd150;
    localparam logic [LEVEL_W-1:0]       HUMIDITY_RESET  = 10'd600;
    localparam logic [LEVEL_W-1:0]       SOIL_DRY_RESET  = 10'd200;
    localparam logic [LEVEL_W-1:0]       LIGHT_RESET     = 10'd300;
    localparam logic [TIME_W-1:0]        PUMP_WORK_RESET = 32'd3000;
    localparam logic [TIME_W-1:0]        PUMP_PAUSE_RESET = 32'd300000;
    localparam logic [TIME_W-1:0]        FAN_MAX_RESET   = 32'd1800000;

endpackage

// ----- hdl/greenhouse_relay_controller.sv -----
// ----------------------------------------------------------------------------
// Greenhouse relay controller
// Turns sensor polls into heater, fan, pump and grow light relay drive.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake         payload
//  -------   ---------  ----------------  ------------------------------------
//  s_        in         s_valid/s_ready   now_ms, temperature, humidity,
//                                         climate_ok, soil_raw, photo_raw
//  m_        out        m_valid/m_ready   heater/fan/pump/light relay, status
//  cfg_      in         cfg_wr_en         cfg_index, cfg_wdata (no read-back)
//
//  One poll per cycle sustained while m_ready stays high; each poll moves from
//  its beat into the input register and then into the result register on m_.
//  The rate is set by the state update loop: the timestamp subtract/compare
//  logic in front of the controller state registers is combinational.
//  Reset (aresetn low, synchronous) turns all relays off, clears the time
//  stamps and loads the default limits.
//  With m_ready low the result holds; s_ready drops only once the input
//  register also holds a poll.
//
module greenhouse_relay_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [grc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // poll input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [grc_pkg::TIME_W-1:0]          s_now_ms,
    input  logic signed [grc_pkg::TEMP_W-1:0]   s_temperature,
    input  logic [grc_pkg::LEVEL_W-1:0]         s_humidity,
    input  logic                                s_climate_ok,
    input  logic [grc_pkg::LEVEL_W-1:0]         s_soil_raw,
    input  logic [grc_pkg::LEVEL_W-1:0]         s_photo_raw,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_heater_relay,
    output logic                                m_fan_relay,
    output logic                                m_pump_relay,
    output logic                                m_light_relay,
    output logic [grc_pkg::STATUS_W-1:0]        m_poll_status
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [grc_pkg::TEMP_W-1:0] temp_high_limit_reg;
    logic signed [grc_pkg::TEMP_W-1:0] temp_low_limit_reg;
    logic [grc_pkg::LEVEL_W-1:0]       humidity_limit_reg;
    logic [grc_pkg::LEVEL_W-1:0]       soil_dry_limit_reg;
    logic [grc_pkg::LEVEL_W-1:0]       light_limit_reg;
    logic [grc_pkg::TIME_W-1:0]        pump_work_ms_reg;
    logic [grc_pkg::TIME_W-1:0]        pump_pause_ms_reg;
    logic [grc_pkg::TIME_W-1:0]        fan_max_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_high_limit_reg <= grc_pkg::TEMP_HIGH_RESET;
            temp_low_limit_reg  <= grc_pkg::TEMP_LOW_RESET;
            humidity_limit_reg  <= grc_pkg::HUMIDITY_RESET;
            soil_dry_limit_reg  <= grc_pkg::SOIL_DRY_RESET;
            light_limit_reg     <= grc_pkg::LIGHT_RESET;
            pump_work_ms_reg    <= grc_pkg::PUMP_WORK_RESET;
            pump_pause_ms_reg   <= grc_pkg::PUMP_PAUSE_RESET;
            fan_max_ms_reg      <= grc_pkg::FAN_MAX_RESET;
        end else if (cfg_wr_en) begin
            case (grc_pkg::cfg_index_t'(cfg_index))
                grc_pkg::REG_TEMP_HIGH_LIMIT: begin
                    temp_high_limit_reg <= $signed(cfg_wdata[grc_pkg::TEMP_W-1:0]);
                end
                grc_pkg::REG_TEMP_LOW_LIMIT: begin
                    temp_low_limit_reg <= $signed(cfg_wdata[grc_pkg::TEMP_W-1:0]);
                end
                grc_pkg::REG_HUMIDITY_LIMIT: begin
                    humidity_limit_reg <= cfg_wdata[grc_pkg::LEVEL_W-1:0];
                end
                grc_pkg::REG_SOIL_DRY_LIMIT: begin
                    soil_dry_limit_reg <= cfg_wdata[grc_pkg::LEVEL_W-1:0];
                end
                grc_pkg::REG_LIGHT_LIMIT: begin
                    light_limit_reg <= cfg_wdata[grc_pkg::LEVEL_W-1:0];
                end
                grc_pkg::REG_PUMP_WORK_MS: begin
                    pump_work_ms_reg <= cfg_wdata[grc_pkg::TIME_W-1:0];
                end
                grc_pkg::REG_PUMP_PAUSE_MS: begin
                    pump_pause_ms_reg <= cfg_wdata[grc_pkg::TIME_W-1:0];
                end
                grc_pkg::REG_FAN_MAX_MS: begin
                    fan_max_ms_reg <= cfg_wdata[grc_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> rule logic -> result register.
    // advance moves the held poll into the result register and commits
    // its state update in the same edge.
    // ------------------------------------------------------------------
    logic in_valid_reg, in_valid_next;
    logic m_valid_reg, m_valid_next;
    logic advance;
    logic s_beat;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_beat  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Input register payload: load on every accepted beat.
    logic [grc_pkg::TIME_W-1:0]        in_now_ms_reg;
    logic signed [grc_pkg::TEMP_W-1:0] in_temperature_reg;
    logic [grc_pkg::LEVEL_W-1:0]       in_humidity_reg;
    logic                              in_climate_ok_reg;
    logic [grc_pkg::LEVEL_W-1:0]       in_soil_raw_reg;
    logic [grc_pkg::LEVEL_W-1:0]       in_photo_raw_reg;

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_now_ms_reg      <= s_now_ms;
            in_temperature_reg <= s_temperature;
            in_humidity_reg    <= s_humidity;
            in_climate_ok_reg  <= s_climate_ok;
            in_soil_raw_reg    <= s_soil_raw;
            in_photo_raw_reg   <= s_photo_raw;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic heater_is_on_reg, heater_is_on_next;
    logic fan_is_on_reg, fan_is_on_next;
    logic pump_is_on_reg, pump_is_on_next;
    logic light_is_on_reg, light_is_on_next;
    logic [grc_pkg::TIME_W-1:0] pump_started_at_reg, pump_started_at_next;
    logic [grc_pkg::TIME_W-1:0] pump_stopped_at_reg, pump_stopped_at_next;
    logic [grc_pkg::TIME_W-1:0] fan_started_at_reg, fan_started_at_next;
    logic [grc_pkg::TIME_W-1:0] last_read_at_reg, last_read_at_next;

    // Rule evaluation for the poll in the input register.
    logic [grc_pkg::TIME_W-1:0] read_elapsed;
    logic [grc_pkg::TIME_W-1:0] pause_elapsed;
    logic [grc_pkg::TIME_W-1:0] pump_elapsed;
    logic [grc_pkg::TIME_W-1:0] fan_elapsed;
    logic [grc_pkg::TIME_W-1:0] pump_started_sel;
    logic [grc_pkg::TIME_W-1:0] fan_started_sel;
    logic poll_early;
    logic humid;
    logic temp_hot;
    logic temp_cold;
    logic fan_request;
    logic fan_start;
    logic fan_timeout;
    logic pause_done;
    logic pump_start;
    logic pump_running;
    logic pump_stop;
    logic light_request;
    logic [grc_pkg::STATUS_W-1:0] status_sel;

    always_comb begin
        // Wrapping time differences: plain modulo-2^32 subtraction.
        read_elapsed = in_now_ms_reg - last_read_at_reg;
        poll_early   = read_elapsed < grc_pkg::POLL_GAP_MS;

        humid     = in_humidity_reg >= humidity_limit_reg;
        temp_hot  = in_temperature_reg >= temp_high_limit_reg;
        temp_cold = in_temperature_reg <= temp_low_limit_reg;

        // Fan wanted by either temperature band or high humidity; the
        // start stamp moves only on an off-to-on edge.
        fan_request     = temp_hot || temp_cold || humid;
        fan_start       = fan_request && !fan_is_on_reg;
        fan_started_sel = fan_start ? in_now_ms_reg : fan_started_at_reg;
        fan_elapsed     = in_now_ms_reg - fan_started_sel;
        fan_timeout     = fan_request && (fan_elapsed >= fan_max_ms_reg);

        // Pump pulse: skip watering entirely until the pause has run out.
        pause_elapsed    = in_now_ms_reg - pump_stopped_at_reg;
        pause_done       = pause_elapsed >= pump_pause_ms_reg;
        pump_start       = pause_done && !pump_is_on_reg
                           && (in_soil_raw_reg < soil_dry_limit_reg);
        pump_started_sel = pump_start ? in_now_ms_reg : pump_started_at_reg;
        pump_running     = pump_is_on_reg || pump_start;
        pump_elapsed     = in_now_ms_reg - pump_started_sel;
        pump_stop        = pause_done && pump_running
                           && (pump_elapsed >= pump_work_ms_reg);

        // 1023 - photo on ten bits is the bitwise inverse.
        light_request = (~in_photo_raw_reg) <= light_limit_reg;

        // Default: hold all state.
        heater_is_on_next    = heater_is_on_reg;
        fan_is_on_next       = fan_is_on_reg;
        pump_is_on_next      = pump_is_on_reg;
        light_is_on_next     = light_is_on_reg;
        pump_started_at_next = pump_started_at_reg;
        pump_stopped_at_next = pump_stopped_at_reg;
        fan_started_at_next  = fan_started_at_reg;
        last_read_at_next    = last_read_at_reg;

        if (poll_early) begin
            status_sel = grc_pkg::POLL_EARLY;
        end else if (!in_climate_ok_reg) begin
            status_sel = grc_pkg::POLL_FAULT;
        end else begin
            status_sel = grc_pkg::POLL_REGULATED;
            if (advance) begin
                last_read_at_next    = in_now_ms_reg;
                heater_is_on_next    = !temp_hot && temp_cold;
                // Forced stop leaves the start stamp where it was.
                fan_is_on_next       = fan_request && !fan_timeout;
                fan_started_at_next  = fan_started_sel;
                pump_started_at_next = pump_started_sel;
                pump_is_on_next      = pause_done ? (pump_running && !pump_stop)
                                                  : pump_is_on_reg;
                if (pump_stop) begin
                    pump_stopped_at_next = in_now_ms_reg;
                end
                light_is_on_next     = light_request;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heater_is_on_reg    <= 1'b0;
            fan_is_on_reg       <= 1'b0;
            pump_is_on_reg      <= 1'b0;
            light_is_on_reg     <= 1'b0;
            pump_started_at_reg <= '0;
            pump_stopped_at_reg <= '0;
            fan_started_at_reg  <= '0;
            last_read_at_reg    <= '0;
        end else begin
            heater_is_on_reg    <= heater_is_on_next;
            fan_is_on_reg       <= fan_is_on_next;
            pump_is_on_reg      <= pump_is_on_next;
            light_is_on_reg     <= light_is_on_next;
            pump_started_at_reg <= pump_started_at_next;
            pump_stopped_at_reg <= pump_stopped_at_next;
            fan_started_at_reg  <= fan_started_at_next;
            last_read_at_reg    <= last_read_at_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: report the relays as they stand after this poll.
    // ------------------------------------------------------------------
    logic m_heater_reg;
    logic m_fan_reg;
    logic m_pump_reg;
    logic m_light_reg;
    logic [grc_pkg::STATUS_W-1:0] m_status_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_heater_reg <= heater_is_on_next;
            m_fan_reg    <= fan_is_on_next;
            m_pump_reg   <= pump_is_on_next;
            m_light_reg  <= light_is_on_next;
            m_status_reg <= status_sel;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_heater_relay = m_heater_reg;
    assign m_fan_relay    = m_fan_reg;
    assign m_pump_relay   = m_pump_reg;
    assign m_light_relay  = m_light_reg;
    assign m_poll_status  = m_status_reg;

endmodule

// ----- hdl/grc_checker.sv -----
// ----------------------------------------------------------------------------
// Greenhouse relay controller checker
// Port-level properties of the relay controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "greenhouse_relay_controller_defines.svh"

module grc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_heater_relay,
    input logic                                m_fan_relay,
    input logic                                m_pump_relay,
    input logic                                m_light_relay,
    input logic [grc_pkg::STATUS_W-1:0]        m_poll_status
);

    logic m_stall;
    logic status_known;

    assign m_stall      = m_valid && !m_ready;
    assign status_known = (m_poll_status == grc_pkg::POLL_EARLY)
                          || (m_poll_status == grc_pkg::POLL_FAULT)
                          || (m_poll_status == grc_pkg::POLL_REGULATED);

    // A stalled result beat holds.
    `GRC_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_stall, m_valid && $stable({m_heater_relay, m_fan_relay, m_pump_relay, m_light_relay, m_poll_status}))

    // Every delivered beat carries a defined status code.
    `GRC_ASSERT_NOW(a_status_known, aclk, aresetn, m_valid, status_known)

    // Input side backs up only behind a stalled result.
    `GRC_ASSERT_NOW(a_ready_backpressure, aclk, aresetn, !s_ready, m_stall)

    // Reset drops the result channel.
    `GRC_ASSERT_NEXT(a_reset_drops_valid, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind greenhouse_relay_controller grc_checker u_grc_checker (.*);

// ----- tb/sv/tb_greenhouse_relay_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greenhouse relay controller testbench
// Runs a table of directed polls and then randomized polls under a series of
// limit and timer settings. Both channels stall at random. Each result beat
// is scored against an untimed model of the relay rules kept in this file.
// ----------------------------------------------------------------------------
module tb_greenhouse_relay_controller;

    localparam int TIME_W      = grc_pkg::TIME_W;
    localparam int TEMP_W      = grc_pkg::TEMP_W;
    localparam int LEVEL_W     = grc_pkg::LEVEL_W;
    localparam int STATUS_W    = grc_pkg::STATUS_W;
    localparam int CFG_DATA_W  = grc_pkg::CFG_DATA_W;

    localparam int NUM_REGS    = 8;
    localparam int PHASE_POLLS = 115;
    localparam int HOLD_OFF    = 250;       // long receiver stall, in cycles
    localparam int HOLD_AT     = 300;       // result count that triggers it
    localparam logic [LEVEL_W-1:0] FULL_SCALE = 10'd1023;

    typedef struct {
        logic [TIME_W-1:0]        now_ms;
        logic signed [TEMP_W-1:0] temperature;
        logic [LEVEL_W-1:0]       humidity;
        logic                     climate_ok;
        logic [LEVEL_W-1:0]       soil_raw;
        logic [LEVEL_W-1:0]       photo_raw;
    } poll_t;

    typedef struct packed {
        logic                  heater;
        logic                  fan;
        logic                  pump;
        logic                  light;
        grc_pkg::poll_status_t status;
    } relay_drive_t;

    typedef enum bit {ROW_POLL, ROW_WRITE} row_kind_t;

    // One line of the directed table. A pinned row carries a status typed in
    // by hand, with every relay expected off.
    typedef struct {
        row_kind_t              kind;
        grc_pkg::cfg_index_t    reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        poll_t                  poll;
        bit                     pinned;
        grc_pkg::poll_status_t  pinned_status;
    } script_row_t;

    typedef enum int {TUNE_TYPICAL, TUNE_FLOOR, TUNE_CEILING, TUNE_SPREAD, TUNE_RAW} tune_t;

    // ------------------------------------------------------------------------
    // Clock and DUT signals
    // ------------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic                     cfg_wr_en;
    grc_pkg::cfg_index_t      cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [TIME_W-1:0]        s_now_ms;
    logic signed [TEMP_W-1:0] s_temperature;
    logic [LEVEL_W-1:0]       s_humidity;
    logic                     s_climate_ok;
    logic [LEVEL_W-1:0]       s_soil_raw;
    logic [LEVEL_W-1:0]       s_photo_raw;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_heater_relay;
    logic                     m_fan_relay;
    logic                     m_pump_relay;
    logic                     m_light_relay;
    logic [STATUS_W-1:0]      m_poll_status;

    greenhouse_relay_controller dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_now_ms       (s_now_ms),
        .s_temperature  (s_temperature),
        .s_humidity     (s_humidity),
        .s_climate_ok   (s_climate_ok),
        .s_soil_raw     (s_soil_raw),
        .s_photo_raw    (s_photo_raw),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_heater_relay (m_heater_relay),
        .m_fan_relay    (m_fan_relay),
        .m_pump_relay   (m_pump_relay),
        .m_light_relay  (m_light_relay),
        .m_poll_status  (m_poll_status)
    );

    // ------------------------------------------------------------------------
    // Shadow of the controller: limits as written, relays and time stamps
    // ------------------------------------------------------------------------
    logic signed [TEMP_W-1:0] hot_limit, cold_limit;
    logic [LEVEL_W-1:0]       humid_limit, dry_limit, dark_limit;
    logic [TIME_W-1:0]        water_ms, rest_ms, fan_cap_ms;
    logic                     heater_state, fan_state, pump_state, lamp_state;
    logic [TIME_W-1:0]        pump_start_ms, pump_stop_ms, fan_start_ms, last_poll_ms;

    relay_drive_t expected_drive[$];    // predicted beats, oldest first
    script_row_t  script[$];
    int           mismatch_count = 0;
    logic [TIME_W-1:0] poll_clock;      // running timestamp of random polls
    bit           sender_calm = 1'b0;

    // Stamp the fan start time only on an off-to-on transition.
    function automatic void switch_fan(input logic on, input logic [TIME_W-1:0] now);
        if (on && !fan_state)
            fan_start_ms = now;
        fan_state = on;
    endfunction

    // Apply one poll to the shadow and return the beat it should produce.
    function automatic relay_drive_t regulate(input poll_t p);
        relay_drive_t r;
        logic humid;
        logic [TIME_W-1:0] since_read, since_stop, since_start, fan_run;
        since_read = p.now_ms - last_poll_ms;
        if (since_read < grc_pkg::POLL_GAP_MS) begin
            r.status = grc_pkg::POLL_EARLY;
        end else if (!p.climate_ok) begin
            r.status = grc_pkg::POLL_FAULT;
        end else begin
            humid = p.humidity >= humid_limit;
            r.status = grc_pkg::POLL_REGULATED;
            last_poll_ms = p.now_ms;

            if (p.temperature >= hot_limit) begin
                heater_state = 1'b0;
                switch_fan(1'b1, p.now_ms);
            end else if (p.temperature <= cold_limit) begin
                heater_state = 1'b1;
                switch_fan(1'b1, p.now_ms);
            end else begin
                if (!humid)
                    switch_fan(1'b0, p.now_ms);
                heater_state = 1'b0;
            end
            if (humid)
                switch_fan(1'b1, p.now_ms);

            // Watering is skipped while the pause after the last stop runs.
            since_stop = p.now_ms - pump_stop_ms;
            if (since_stop >= rest_ms) begin
                if (!pump_state && p.soil_raw < dry_limit) begin
                    pump_state = 1'b1;
                    pump_start_ms = p.now_ms;
                end
                since_start = p.now_ms - pump_start_ms;
                if (pump_state && since_start >= water_ms) begin
                    pump_state = 1'b0;
                    pump_stop_ms = p.now_ms;
                end
            end

            lamp_state = (FULL_SCALE - p.photo_raw) <= dark_limit;

            // Cut the fan after its maximum run; the start stamp stays.
            fan_run = p.now_ms - fan_start_ms;
            if (fan_state && fan_run >= fan_cap_ms)
                fan_state = 1'b0;
        end
        r.heater = heater_state;
        r.fan    = fan_state;
        r.pump   = pump_state;
        r.light  = lamp_state;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void add_poll(input logic [TIME_W-1:0] now, input int temp,
                                     input int hum, input logic ok, input int soil,
                                     input int photo, input bit pinned = 1'b0,
                                     input grc_pkg::poll_status_t pinned_status =
                                         grc_pkg::POLL_EARLY);
        script_row_t r;
        r.kind               = ROW_POLL;
        r.reg_index          = grc_pkg::REG_TEMP_HIGH_LIMIT;
        r.reg_value          = '0;
        r.poll.now_ms        = now;
        r.poll.temperature   = temp[TEMP_W-1:0];
        r.poll.humidity      = hum[LEVEL_W-1:0];
        r.poll.climate_ok    = ok;
        r.poll.soil_raw      = soil[LEVEL_W-1:0];
        r.poll.photo_raw     = photo[LEVEL_W-1:0];
        r.pinned             = pinned;
        r.pinned_status      = pinned_status;
        script.push_back(r);
    endfunction

    function automatic void add_write(input grc_pkg::cfg_index_t idx,
                                      input logic [CFG_DATA_W-1:0] value);
        script_row_t r;
        r.kind          = ROW_WRITE;
        r.reg_index     = idx;
        r.reg_value     = value;
        r.poll          = '{default: '0};
        r.pinned        = 1'b0;
        r.pinned_status = grc_pkg::POLL_EARLY;
        script.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Random poll: mostly timestamps that step past the read interval, with
    // early polls, boundary steps and wild jumps mixed in; levels cluster
    // around the current limits so every comparison flips both ways.
    // ------------------------------------------------------------------------
    function automatic poll_t random_poll();
        poll_t p;
        int pick, t;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            poll_clock += $urandom_range(1000, 2500);
        else if (pick < 80)
            poll_clock += $urandom_range(0, 999);
        else if (pick < 88)
            poll_clock += pick[0] ? 32'd999 : 32'd1000;
        else if (pick < 94)
            poll_clock += $urandom_range(1000, 400000);
        else
            poll_clock = $urandom;
        p.now_ms = poll_clock;

        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            p.temperature = TEMP_W'($urandom);
        end else if (pick < 25) begin
            p.temperature = hot_limit + TEMP_W'($urandom_range(0, 2)) - TEMP_W'(1);
        end else if (pick < 35) begin
            p.temperature = cold_limit + TEMP_W'($urandom_range(0, 2)) - TEMP_W'(1);
        end else begin
            t = int'($urandom_range(0, 1200)) - 400;
            p.temperature = t[TEMP_W-1:0];
        end

        pick = $urandom_range(0, 99);
        if (pick < 10)
            p.humidity = LEVEL_W'($urandom);
        else if (pick < 25)
            p.humidity = humid_limit + LEVEL_W'($urandom_range(0, 2)) - LEVEL_W'(1);
        else
            p.humidity = LEVEL_W'($urandom_range(0, 1000));

        p.climate_ok = $urandom_range(0, 99) < 92;

        if ($urandom_range(0, 99) < 15)
            p.soil_raw = dry_limit + LEVEL_W'($urandom_range(0, 2)) - LEVEL_W'(1);
        else
            p.soil_raw = LEVEL_W'($urandom);

        if ($urandom_range(0, 99) < 15)
            p.photo_raw = (FULL_SCALE - dark_limit) + LEVEL_W'($urandom_range(0, 2))
                          - LEVEL_W'(1);
        else
            p.photo_raw = LEVEL_W'($urandom);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one poll, predict its beat, and return at the edge it is taken.
    task automatic offer_poll(input poll_t p, input bit pinned,
                              input grc_pkg::poll_status_t pinned_status);
        int gap;
        relay_drive_t want;
        // Toggle now and then between bursts without gaps and random gaps.
        if ($urandom_range(0, 29) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_now_ms      <= p.now_ms;
        s_temperature <= p.temperature;
        s_humidity    <= p.humidity;
        s_climate_ok  <= p.climate_ok;
        s_soil_raw    <= p.soil_raw;
        s_photo_raw   <= p.photo_raw;
        s_valid       <= 1'b1;
        // Predict at offer time: valid holds until taken, so order is kept.
        want = regulate(p);
        if (pinned) begin
            want = '0;
            want.status = pinned_status;
        end
        expected_drive.push_back(want);
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait for every predicted beat to drain.
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_drive.size() != 0);
        @(posedge aclk);
    endtask

    // Write one register and mirror it into the shadow limits.
    task automatic write_register(input grc_pkg::cfg_index_t idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            grc_pkg::REG_TEMP_HIGH_LIMIT: hot_limit   = data[TEMP_W-1:0];
            grc_pkg::REG_TEMP_LOW_LIMIT:  cold_limit  = data[TEMP_W-1:0];
            grc_pkg::REG_HUMIDITY_LIMIT:  humid_limit = data[LEVEL_W-1:0];
            grc_pkg::REG_SOIL_DRY_LIMIT:  dry_limit   = data[LEVEL_W-1:0];
            grc_pkg::REG_LIGHT_LIMIT:     dark_limit  = data[LEVEL_W-1:0];
            grc_pkg::REG_PUMP_WORK_MS:    water_ms    = data;
            grc_pkg::REG_PUMP_PAUSE_MS:   rest_ms     = data;
            grc_pkg::REG_FAN_MAX_MS:      fan_cap_ms  = data;
            default: ;
        endcase
    endtask

    // Retune every register while idle, then run a batch of random polls.
    task automatic run_phase(input tune_t how);
        logic [CFG_DATA_W-1:0] v [NUM_REGS];
        settle();
        case (how)
            TUNE_TYPICAL: begin
                v[grc_pkg::REG_TEMP_HIGH_LIMIT] = 300;
                v[grc_pkg::REG_TEMP_LOW_LIMIT]  = 150;
                v[grc_pkg::REG_HUMIDITY_LIMIT]  = 600;
                v[grc_pkg::REG_SOIL_DRY_LIMIT]  = 200;
                v[grc_pkg::REG_LIGHT_LIMIT]     = 300;
                v[grc_pkg::REG_PUMP_WORK_MS]    = 3000;
                v[grc_pkg::REG_PUMP_PAUSE_MS]   = 6000;
                v[grc_pkg::REG_FAN_MAX_MS]      = 12000;
            end
            TUNE_FLOOR: begin
                v[grc_pkg::REG_TEMP_HIGH_LIMIT] = CFG_DATA_W'(-400);
                v[grc_pkg::REG_TEMP_LOW_LIMIT]  = CFG_DATA_W'(-400);
                v[grc_pkg::REG_HUMIDITY_LIMIT]  = 0;
                v[grc_pkg::REG_SOIL_DRY_LIMIT]  = 0;
                v[grc_pkg::REG_LIGHT_LIMIT]     = 0;
                v[grc_pkg::REG_PUMP_WORK_MS]    = 0;
                v[grc_pkg::REG_PUMP_PAUSE_MS]   = 0;
                v[grc_pkg::REG_FAN_MAX_MS]      = 0;
            end
            TUNE_CEILING: begin
                v[grc_pkg::REG_TEMP_HIGH_LIMIT] = 800;
                v[grc_pkg::REG_TEMP_LOW_LIMIT]  = 800;
                v[grc_pkg::REG_HUMIDITY_LIMIT]  = 1000;
                v[grc_pkg::REG_SOIL_DRY_LIMIT]  = 1023;
                v[grc_pkg::REG_LIGHT_LIMIT]     = 1023;
                v[grc_pkg::REG_PUMP_WORK_MS]    = '1;
                v[grc_pkg::REG_PUMP_PAUSE_MS]   = '1;
                v[grc_pkg::REG_FAN_MAX_MS]      = '1;
            end
            TUNE_SPREAD: begin
                v[grc_pkg::REG_TEMP_HIGH_LIMIT] =
                    CFG_DATA_W'(int'($urandom_range(0, 1200)) - 400);
                v[grc_pkg::REG_TEMP_LOW_LIMIT]  =
                    CFG_DATA_W'(int'($urandom_range(0, 1200)) - 400);
                v[grc_pkg::REG_HUMIDITY_LIMIT]  = $urandom_range(0, 1000);
                v[grc_pkg::REG_SOIL_DRY_LIMIT]  = $urandom_range(0, 1023);
                v[grc_pkg::REG_LIGHT_LIMIT]     = $urandom_range(0, 1023);
                v[grc_pkg::REG_PUMP_WORK_MS]    = $urandom_range(0, 6000);
                v[grc_pkg::REG_PUMP_PAUSE_MS]   = $urandom_range(0, 20000);
                v[grc_pkg::REG_FAN_MAX_MS]      = $urandom_range(0, 30000);
            end
            default: begin
                // Raw words: upper bits must be dropped, limits may be out of range.
                for (int i = 0; i < NUM_REGS; i++)
                    v[i] = $urandom;
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++)
            write_register(grc_pkg::cfg_index_t'(i), v[i]);
        repeat (PHASE_POLLS)
            offer_poll(random_poll(), 1'b0, grc_pkg::POLL_EARLY);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold every input at a known value and load the reset shadow.
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = grc_pkg::REG_TEMP_HIGH_LIMIT;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_now_ms      = '0;
        s_temperature = '0;
        s_humidity    = '0;
        s_climate_ok  = 1'b0;
        s_soil_raw    = '0;
        s_photo_raw   = '0;

        hot_limit     = grc_pkg::TEMP_HIGH_RESET;
        cold_limit    = grc_pkg::TEMP_LOW_RESET;
        humid_limit   = grc_pkg::HUMIDITY_RESET;
        dry_limit     = grc_pkg::SOIL_DRY_RESET;
        dark_limit    = grc_pkg::LIGHT_RESET;
        water_ms      = grc_pkg::PUMP_WORK_RESET;
        rest_ms       = grc_pkg::PUMP_PAUSE_RESET;
        fan_cap_ms    = grc_pkg::FAN_MAX_RESET;
        heater_state  = 1'b0;
        fan_state     = 1'b0;
        pump_state    = 1'b0;
        lamp_state    = 1'b0;
        pump_start_ms = '0;
        pump_stop_ms  = '0;
        fan_start_ms  = '0;
        last_poll_ms  = '0;

        // Directed table, run under the reset limits until its own register writes.
        // First polls land inside the read interval after reset.
        add_poll(0,   200, 0, 1'b1, 0, 1023, 1'b1, grc_pkg::POLL_EARLY);
        add_poll(999, 200, 0, 1'b1, 0, 1023, 1'b1, grc_pkg::POLL_EARLY);
        // Failed climate read with every other field at an extreme.
        add_poll(1000, -1024, 1023, 1'b0, 1023, 0, 1'b1, grc_pkg::POLL_FAULT);
        // Dry soil, but the pump pause after time zero still runs.
        add_poll(1000, 200, 0, 1'b1, 0, 1023);
        // Temperature extremes, in and out of range; fan start stamped once.
        add_poll(2000, 800,   1000, 1'b1, 1023, 0);
        add_poll(3000, -400,  1000, 1'b1, 1023, 0);
        add_poll(4000, 1023,  1023, 1'b1, 512, 512);
        add_poll(5000, -1024, 0,    1'b1, 512, 512);
        // Exactly at the limits; humidity keeps the fan running.
        add_poll(6000, 300, 599, 1'b1, 200, 723);
        add_poll(7000, 150, 600, 1'b1, 200, 724);
        add_poll(8000, 200, 600, 1'b1, 1023, 0);
        // Pump pulse: start once the pause ends, stop after work time, pause.
        add_poll(300000, 200, 1000, 1'b1, 199, 723);
        add_poll(302000, 200, 1000, 1'b1, 0, 722);
        add_poll(303000, 200, 1000, 1'b1, 0, 0);
        add_poll(304000, 200, 1000, 1'b1, 0, 0);
        // Fan running since the first hot poll: forced off, then restarts.
        add_poll(1802000, 800, 1000, 1'b1, 1023, 0);
        add_poll(1803000, 800, 1000, 1'b1, 1023, 0);
        // Zero work time: start and stop within the same poll.
        add_write(grc_pkg::REG_PUMP_WORK_MS, 0);
        add_write(grc_pkg::REG_PUMP_PAUSE_MS, 0);
        add_poll(1804000, 200, 0, 1'b1, 0, 0);
        // Light always on at the top limit; timestamps wrap around zero.
        add_write(grc_pkg::REG_LIGHT_LIMIT, 1023);
        add_poll(32'hFFFF_FFFF, 200, 0, 1'b1, 1023, 1023);
        add_poll(32'h0000_03E7, 200, 0, 1'b1, 1023, 0);
        add_poll(32'h0000_03E8, 200, 0, 1'b1, 1023, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                settle();
                write_register(script[i].reg_index, script[i].reg_value);
            end else begin
                offer_poll(script[i].poll, script[i].pinned, script[i].pinned_status);
            end
        end

        // Random polls under a sweep of settings, extremes included.
        poll_clock = 32'h0000_03E8;
        run_phase(TUNE_TYPICAL);
        run_phase(TUNE_FLOOR);
        run_phase(TUNE_CEILING);
        run_phase(TUNE_SPREAD);
        run_phase(TUNE_RAW);
        run_phase(TUNE_TYPICAL);
        run_phase(TUNE_SPREAD);
        run_phase(TUNE_RAW);

        // Drain, then let the pipeline sit idle before the verdict.
        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls per beat, stall-free stretches, and one long
    // hold-off so the block backs up and drops s_ready.
    // ------------------------------------------------------------------------
    initial begin
        int  gap;
        int  served;
        bit  calm;
        served  = 0;
        calm    = 1'b0;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 6);
            if (served == HOLD_AT)
                gap = HOLD_OFF;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            served++;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [STATUS_W-1:0] want,
                                        input logic [STATUS_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        relay_drive_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_drive.size() == 0) begin
                $display("%0t ns: result beat with no poll pending, expected none, actual status %0d",
                         $time, m_poll_status);
                mismatch_count++;
            end else begin
                want = expected_drive.pop_front();
                check_field("heater_relay", want.heater, m_heater_relay);
                check_field("fan_relay",    want.fan,    m_fan_relay);
                check_field("pump_relay",   want.pump,   m_pump_relay);
                check_field("light_relay",  want.light,  m_light_relay);
                check_field("poll_status",  want.status, m_poll_status);
            end
        end
    end

    // Stop a hung run well past the slowest legal finish.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- greenhouse_relay_controller.f -----
+incdir+hdl
hdl/grc_pkg.sv
hdl/greenhouse_relay_controller.sv
hdl/grc_checker.sv
tb/sv/tb_greenhouse_relay_controller.sv
